### rtl/core/sum8d_pkg.sv
package sum8d_pkg;

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhLen  = 2'd1,
    PhPay  = 2'd2,
    PhSum  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    KindRaw     = 3'd0,
    KindPayload = 3'd1,
    KindGood    = 3'd2,
    KindBad     = 3'd3,
    KindCleared = 3'd4
  } kind_e;

  localparam logic OpReceive = 1'b0;
  localparam logic OpClear   = 1'b1;

  localparam logic [7:0] HeaderReset = 8'hA0;

  localparam int unsigned OutDataW = 96;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  payload_length;
    logic [7:0]  bytes_left;
    logic [7:0]  running_sum;
    logic [31:0] good_count;
    logic [31:0] error_count;
  } frame_state_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    logic [7:0]  frame_length;
    logic [31:0] good_frames;
    logic [31:0] checksum_errors;
    logic [8:0]  held_bytes;
  } result_t;

endpackage

### rtl/core/sum8_length_frame_deframer_unit.sv
// channel   direction  beat contents
// s_axis    in         tuser: op; tdata: data_byte
// m_axis    out        tuser: kind; tdata: out_byte, frame_length, good_frames,
//                      checksum_errors, held_bytes (lowest first), zero padded
// cfg       in         cfg_data_i: header_value
//
// one input beat per cycle unless m_axis stalls; its result, if any, appears on m_axis the next cycle
// the frame state and the result register are the only stages
// while the result register holds an untaken beat, s_axis waits only if
// m_axis_tready is low as well
// reset clears the frame state and both counters and sets the header to 0xa0
module sum8_length_frame_deframer_unit import sum8d_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // data_byte
  input  logic                s_axis_tuser,   // op
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // out_byte, frame_length, good_frames,
                                              // checksum_errors, held_bytes, zeros
  output logic [2:0]          m_axis_tuser,   // kind
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i
);

  frame_state_t state_q, state_d;
  result_t      res_q, res_d;
  logic         res_valid_d;
  logic         out_valid_q;
  logic [7:0]   header_q;
  logic         in_accept;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  sum8d_step u_step (
    .state_i     (state_q),
    .header_i    (header_q),
    .op_i        (s_axis_tuser),
    .data_byte_i (s_axis_tdata),
    .state_o     (state_d),
    .res_o       (res_d),
    .res_valid_o (res_valid_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase          <= PhIdle;
      state_q.payload_length <= 8'd0;
      state_q.bytes_left     <= 8'd0;
      state_q.running_sum    <= 8'd0;
      state_q.good_count     <= 32'd0;
      state_q.error_count    <= 32'd0;
      header_q               <= HeaderReset;
      out_valid_q            <= 1'b0;
    end else begin
      if (in_accept) state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) header_q <= cfg_data_i;
      if (in_accept) begin
        out_valid_q <= res_valid_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && res_valid_d) res_q <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.kind;
  assign m_axis_tdata  = {7'd0, res_q.held_bytes, res_q.checksum_errors,
                          res_q.good_frames, res_q.frame_length, res_q.out_byte};

endmodule

### rtl/core/sum8d_step.sv
module sum8d_step import sum8d_pkg::*; (
  input  frame_state_t state_i,
  input  logic [7:0]   header_i,
  input  logic         op_i,
  input  logic [7:0]   data_byte_i,
  output frame_state_t state_o,
  output result_t      res_o,
  output logic         res_valid_o
);

  logic [7:0] sum_add;
  logic [7:0] left_dec;
  logic [7:0] pay_taken;

  assign sum_add   = state_i.running_sum + data_byte_i;
  assign left_dec  = state_i.bytes_left - 8'd1;
  assign pay_taken = state_i.payload_length - state_i.bytes_left;

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o.kind            = KindRaw;
    res_o.out_byte        = data_byte_i;
    res_o.frame_length    = 8'd0;
    res_o.good_frames     = state_i.good_count;
    res_o.checksum_errors = state_i.error_count;
    res_o.held_bytes      = 9'd0;

    if (op_i == OpClear) begin
      if (state_i.phase != PhIdle) begin
        res_valid_o    = 1'b1;
        res_o.kind     = KindCleared;
        res_o.out_byte = 8'd0;
        case (state_i.phase)
          PhLen: begin
            res_o.held_bytes   = 9'd1;
            res_o.frame_length = 8'd0;
          end
          PhPay: begin
            res_o.held_bytes   = 9'd2 + {1'b0, pay_taken};
            res_o.frame_length = state_i.payload_length;
          end
          default: begin
            res_o.held_bytes   = 9'd2 + {1'b0, state_i.payload_length};
            res_o.frame_length = state_i.payload_length;
          end
        endcase
        state_o.phase          = PhIdle;
        state_o.payload_length = 8'd0;
        state_o.bytes_left     = 8'd0;
        state_o.running_sum    = 8'd0;
      end
    end else begin
      case (state_i.phase)
        PhIdle: begin
          if (data_byte_i == header_i) begin
            state_o.phase       = PhLen;
            state_o.running_sum = data_byte_i;
          end else begin
            res_valid_o = 1'b1;
          end
        end
        PhLen: begin
          state_o.payload_length = data_byte_i;
          state_o.bytes_left     = data_byte_i;
          state_o.running_sum    = sum_add;
          state_o.phase          = (data_byte_i == 8'd0) ? PhSum : PhPay;
        end
        PhPay: begin
          state_o.running_sum = sum_add;
          state_o.bytes_left  = left_dec;
          if (left_dec == 8'd0) state_o.phase = PhSum;
          res_valid_o        = 1'b1;
          res_o.kind         = KindPayload;
          res_o.frame_length = state_i.payload_length;
          // one more payload byte than were taken before this beat
          res_o.held_bytes   = 9'd3 + {1'b0, pay_taken};
        end
        default: begin
          res_valid_o        = 1'b1;
          res_o.frame_length = state_i.payload_length;
          if (state_i.running_sum == data_byte_i) begin
            state_o.good_count = state_i.good_count + 32'd1;
            res_o.kind         = KindGood;
          end else begin
            state_o.error_count = state_i.error_count + 32'd1;
            res_o.kind          = KindBad;
          end
          res_o.good_frames      = state_o.good_count;
          res_o.checksum_errors  = state_o.error_count;
          state_o.phase          = PhIdle;
          state_o.payload_length = 8'd0;
          state_o.bytes_left     = 8'd0;
          state_o.running_sum    = 8'd0;
        end
      endcase
    end
  end

endmodule

### rtl/core/sum8d_checker.sv
module sum8d_checker import sum8d_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [2:0]          m_axis_tuser
);

  // a stalled result beat keeps its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // raw echo beats and frame ends carry no held bytes
  a_raw_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KindRaw |->
      m_axis_tdata[15:8] == 8'd0 && m_axis_tdata[88:80] == 9'd0)
    else $error("raw beat with frame length or held bytes");

  a_end_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KindGood || m_axis_tuser == KindBad) |->
      m_axis_tdata[88:80] == 9'd0)
    else $error("frame end with held bytes");

  // payload beat counts header, length and at least itself
  a_payload_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KindPayload |->
      m_axis_tdata[88:80] >= 9'd3 &&
      m_axis_tdata[88:80] <= 9'd2 + {1'b0, m_axis_tdata[15:8]})
    else $error("payload beat with held count out of range");

  a_clear_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KindCleared |->
      m_axis_tdata[7:0] == 8'd0 && m_axis_tdata[88:80] != 9'd0)
    else $error("clear beat with byte or nothing discarded");

endmodule

bind sum8_length_frame_deframer_unit sum8d_checker u_sum8d_checker (.*);

### bench/sum8_length_frame_deframer_unit_tb.sv
module sum8_length_frame_deframer_unit_tb;
  import sum8d_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned HoldCycles = 500;

  // tracks frame state and counters, holds the results still to come
  class deframe_scoreboard;
    logic [7:0]  header;
    phase_e      phase;
    logic [7:0]  frame_len;
    logic [7:0]  left;
    logic [7:0]  sum;
    logic [31:0] good_cnt;
    logic [31:0] bad_cnt;
    result_t     expected_q[$];
    int unsigned errors;

    function new();
      errors = 0;
      reset_state();
    endfunction

    function void go_idle();
      phase = PhIdle;
      frame_len = 8'd0;
      left = 8'd0;
      sum = 8'd0;
    endfunction

    function void reset_state();
      header = HeaderReset;
      good_cnt = 32'd0;
      bad_cnt = 32'd0;
      go_idle();
    endfunction

    function void set_header(logic [7:0] v);
      header = v;
    endfunction

    function logic [8:0] bytes_held();
      logic [7:0] done;
      done = frame_len - left;
      case (phase)
        PhLen: return 9'd1;
        PhPay: return 9'd2 + {1'b0, done};
        PhSum: return 9'd2 + {1'b0, frame_len};
        default: return 9'd0;
      endcase
    endfunction

    function void push(kind_e k, logic [7:0] b, logic [7:0] len, logic [8:0] held);
      result_t r;
      r.kind = k;
      r.out_byte = b;
      r.frame_length = len;
      r.good_frames = good_cnt;
      r.checksum_errors = bad_cnt;
      r.held_bytes = held;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void note_beat(logic op, logic [7:0] b);
      logic [8:0] held;
      logic [7:0] len;
      if (op == OpClear) begin
        if (phase == PhIdle) return;
        held = bytes_held();
        len = (phase == PhLen) ? 8'd0 : frame_len;
        go_idle();
        push(KindCleared, 8'd0, len, held);
        return;
      end
      case (phase)
        PhIdle: begin
          if (b == header) begin
            phase = PhLen;
            sum = b;
          end else begin
            push(KindRaw, b, 8'd0, 9'd0);
          end
        end
        PhLen: begin
          frame_len = b;
          left = b;
          sum = sum + b;
          phase = (b == 8'd0) ? PhSum : PhPay;
        end
        PhPay: begin
          sum = sum + b;
          left = left - 8'd1;
          if (left == 8'd0) phase = PhSum;
          push(KindPayload, b, frame_len, bytes_held());
        end
        default: begin
          len = frame_len;
          if (sum == b) begin
            good_cnt = good_cnt + 32'd1;
            go_idle();
            push(KindGood, b, len, 9'd0);
          end else begin
            bad_cnt = bad_cnt + 32'd1;
            go_idle();
            push(KindBad, b, len, 9'd0);
          end
        end
      endcase
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(logic [2:0] kind, logic [OutDataW-1:0] data);
      result_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected beat: expected none actual kind %0d data %h",
                 $time, kind, data);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      compare("kind", 32'(exp.kind), 32'(kind));
      compare("out_byte", 32'(exp.out_byte), 32'(data[7:0]));
      compare("frame_length", 32'(exp.frame_length), 32'(data[15:8]));
      compare("good_frames", exp.good_frames, data[47:16]);
      compare("checksum_errors", exp.checksum_errors, data[79:48]);
      compare("held_bytes", 32'(exp.held_bytes), 32'(data[88:80]));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                s_valid = 1'b0;
  logic [7:0]          s_data = 8'd0;
  logic                s_user = 1'b0;
  logic                s_ready;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;
  logic [2:0]          m_user;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [7:0]          cfg_data = 8'd0;

  deframe_scoreboard sb = new();
  logic [7:0]  cur_header = HeaderReset;
  bit          smooth = 1'b0;
  int unsigned hold_left = 0;
  int unsigned beats_sent = 0;
  int unsigned cycles = 0;
  bit          big_done = 1'b0;

  sum8_length_frame_deframer_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) sb.check_beat(m_user, m_data);
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (smooth || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // receiver: random stalls plus the long hold-off when asked for
  initial begin
    int unsigned gap_left;
    gap_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_ready <= 1'b0;
        hold_left--;
      end else if (smooth) begin
        m_ready <= 1'b1;
      end else if (gap_left > 0) begin
        m_ready <= 1'b0;
        gap_left--;
      end else begin
        m_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) gap_left = pick_gap();
      end
    end
  end

  task automatic send_beat(logic op, logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user <= op;
    s_data <= b;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    sb.note_beat(op, b);
    beats_sent++;
  endtask

  // header, length, payload, checksum; cut >= 0 clears after that many bytes
  task automatic send_frame(int unsigned len, bit good, int cut);
    logic [7:0] frame_q[$];
    logic [7:0] sum;
    frame_q.insert(frame_q.size(), cur_header);
    frame_q.insert(frame_q.size(), 8'(len));
    sum = cur_header + 8'(len);
    repeat (len) begin
      frame_q.insert(frame_q.size(), 8'($urandom_range(0, 255)));
      sum = sum + frame_q[frame_q.size() - 1];
    end
    frame_q.insert(frame_q.size(), good ? sum : sum + 8'($urandom_range(1, 255)));
    foreach (frame_q[i]) begin
      if (i == cut) begin
        send_beat(OpClear, 8'($urandom_range(0, 255)));
        return;
      end
      send_beat(OpReceive, frame_q[i]);
    end
  endtask

  task automatic drain_and_write(logic [7:0] v);
    s_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_header(v);
    cur_header = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int unsigned n);
    int unsigned target;
    int unsigned r;
    int unsigned len;
    int cut;
    target = beats_sent + n;
    while (beats_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        r = $urandom_range(0, 99);
        if (r < 80) len = $urandom_range(0, 6);
        else if (r < 98) len = $urandom_range(7, 40);
        else len = $urandom_range(41, 120);
        cut = ($urandom_range(0, 11) == 0) ? int'($urandom_range(1, len + 2)) : -1;
        send_frame(len, $urandom_range(0, 3) != 0, cut);
      end else if (r < 88) begin
        send_beat(OpReceive, 8'($urandom_range(0, 255)));
      end else if (r < 94) begin
        send_beat(OpClear, 8'($urandom_range(0, 255)));
      end else begin
        // broken frame: header followed by a few stray bytes
        send_beat(OpReceive, cur_header);
        repeat ($urandom_range(1, 4)) send_beat(OpReceive, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic directed_part();
    send_beat(OpReceive, 8'h00);
    send_beat(OpReceive, 8'hFF);
    send_beat(OpClear, 8'h5A);
    // zero length, checksum equal to the header value
    send_beat(OpReceive, 8'hA0);
    send_beat(OpReceive, 8'h00);
    send_beat(OpReceive, 8'hA0);
    // header value and 0xff inside the payload
    send_beat(OpReceive, 8'hA0);
    send_beat(OpReceive, 8'h02);
    send_beat(OpReceive, 8'hA0);
    send_beat(OpReceive, 8'hFF);
    send_beat(OpReceive, 8'h41);
    // bad checksum
    send_beat(OpReceive, 8'hA0);
    send_beat(OpReceive, 8'h01);
    send_beat(OpReceive, 8'h55);
    send_beat(OpReceive, 8'h00);
    // clear before the length
    send_beat(OpReceive, 8'hA0);
    send_beat(OpClear, 8'hFF);
    // clear mid-payload
    send_beat(OpReceive, 8'hA0);
    send_beat(OpReceive, 8'h03);
    send_beat(OpReceive, 8'h11);
    send_beat(OpClear, 8'h00);
    // header value taken as the length, then cleared
    send_beat(OpReceive, 8'hA0);
    send_beat(OpReceive, 8'hA0);
    send_beat(OpClear, 8'h00);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_part();
    // open a frame, change the header mid-frame, then finish the frame
    send_beat(OpReceive, 8'hA0);
    send_beat(OpReceive, 8'h01);
    drain_and_write(8'h00);
    send_beat(OpReceive, 8'h37);
    send_beat(OpReceive, 8'hD8);

    drain_and_write(8'h00);
    hold_left = HoldCycles;
    run_random(200);

    drain_and_write(8'hFF);
    smooth = 1'b1;
    run_random(200);
    smooth = 1'b0;

    drain_and_write(8'($urandom_range(1, 254)));
    run_random(300);

    drain_and_write(HeaderReset);
    if (!big_done) begin
      send_frame(255, 1'b1, -1);
      big_done = 1'b1;
    end
    run_random(60);

    s_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
